// File: design/ppcg_pkg.sv
// Shared types and constants of the plasma colour generator.
package ppcg_pkg;

	typedef enum logic [1:0] {
		CFG_SPATIAL_SCALE = 2'd0,
		CFG_GRADIENT_MODE = 2'd1,
		CFG_START_COLOR   = 2'd2,
		CFG_END_COLOR     = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] SPATIAL_SCALE_RESET = 16'd256;
	localparam logic [23:0] START_COLOR_RESET   = 24'hFF0000;
	localparam logic [23:0] END_COLOR_RESET     = 24'h0000FF;

	// spatial phase multipliers, turns per Q16.16 unit scaled by 2^32
	localparam logic [31:0] K_SP_010 = 32'd68356528;
	localparam logic [31:0] K_SP_005 = 32'd34178264;

	// temporal phase multipliers, turns per tick scaled by 2^40
	localparam logic [31:0] T_100 = 32'd1749927105;
	localparam logic [31:0] T_130 = 32'd2274905237;
	localparam logic [31:0] T_080 = 32'd1399941684;
	localparam logic [31:0] T_170 = 32'd2974876079;

	localparam logic [63:0] PI_HALF_Q30     = 64'd1686629713;
	localparam logic [63:0] ONE_Q30         = 64'd1073741824;
	localparam logic [63:0] AMP_SHIFT_ROUND = 64'd32768;

	typedef struct packed {
		logic        gradient_mode;
		logic [23:0] start_color;
		logic [23:0] end_color;
	} grad_cfg_t;

endpackage

// File: design/plasma_pattern_color_generator.sv
// Top level of the plasma colour generator: config registers, stage control, output skid.
//
// Each input transfer carries one LED position (pos_x, pos_y, signed Q8.8) and a
// tick count; each output transfer carries the packed colour for it, in order.
// Both channels use valid/ready. One item can enter on every clock while in_ready is high.
// From input transfer to output valid an item passes through
// three input stages, COORD_BITS square-root stages (one root bit each), eight
// wave stages ending in the signed sine value, and five colour stages.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, the last result drops into a one-entry skid register
// and the whole pipeline holds; in_ready falls the next cycle and rises again
// once the skid entry is taken. in_ready depends on no input in the same cycle.
// cfg_we writes register cfg_index (0 spatial_scale, 1 gradient_mode,
// 2 start_color, 3 end_color) from cfg_data at once; write only while idle.
// Reset clears all valid bits and the skid entry and loads the default
// registers: scale 1.0, rainbow mode, red start, blue end.
module plasma_pattern_color_generator #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [23:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic [23:0]                  time_ticks,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [23:0]                  rgb_color
);

	localparam int C   = COORD_BITS;
	localparam int LAT = C + 16;
	localparam int SW  = 3 * C + 25;

	logic [15:0]         spatial_scale_q;
	ppcg_pkg::grad_cfg_t grad_cfg_q;
	logic [LAT-1:0]      vld_q;
	logic                skid_vld_q;
	logic [23:0]         skid_rgb_q;
	logic                en;

	logic signed [C-1:0]   x_s1;
	logic signed [C-1:0]   y_s1;
	logic [23:0]           t_s1;
	logic signed [2*C-1:0] xx_s2;
	logic signed [2*C-1:0] yy_s2;
	logic signed [C:0]     xy_s2;
	logic signed [C-1:0]   x_s2;
	logic signed [C-1:0]   y_s2;
	logic [23:0]           t_s2;
	logic [2*C-1:0]        n_s3;
	logic [SW-1:0]         side_s3;
	logic [SW-1:0]         side_q [C];
	logic [C-1:0]          rad;
	logic signed [C-1:0]   wx;
	logic signed [C-1:0]   wy;
	logic signed [C:0]     wxy;
	logic [23:0]           wt;
	logic signed [15:0]    sines [4];
	logic [23:0]           rgb_last;

	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spatial_scale_q          <= ppcg_pkg::SPATIAL_SCALE_RESET;
			grad_cfg_q.gradient_mode <= 1'b0;
			grad_cfg_q.start_color   <= ppcg_pkg::START_COLOR_RESET;
			grad_cfg_q.end_color     <= ppcg_pkg::END_COLOR_RESET;
		end else if (cfg_we) begin
			unique case (ppcg_pkg::cfg_reg_t'(cfg_index))
				ppcg_pkg::CFG_SPATIAL_SCALE: spatial_scale_q <= cfg_data[15:0];
				ppcg_pkg::CFG_GRADIENT_MODE: grad_cfg_q.gradient_mode <= cfg_data[0];
				ppcg_pkg::CFG_START_COLOR:   grad_cfg_q.start_color <= cfg_data;
				ppcg_pkg::CFG_END_COLOR:     grad_cfg_q.end_color <= cfg_data;
				default:                     grad_cfg_q.end_color <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			skid_vld_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[LAT-2:0], in_valid};
			end
			if (skid_vld_q) begin
				if (out_ready) skid_vld_q <= 1'b0;
			end else if (vld_q[LAT-1] && !out_ready) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	// hold the unaccepted result while the pipeline advances
	always_ff @(posedge clk) begin
		if (en && vld_q[LAT-1] && !out_ready) begin
			skid_rgb_q <= rgb_last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= pos_x;
			y_s1    <= pos_y;
			t_s1    <= time_ticks;
			xx_s2   <= x_s1 * x_s1;
			yy_s2   <= y_s1 * y_s1;
			xy_s2   <= (C+1)'(x_s1) + (C+1)'(y_s1);
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			t_s2    <= t_s1;
			n_s3    <= unsigned'(xx_s2) + unsigned'(yy_s2);
			side_s3 <= {x_s2, y_s2, xy_s2, t_s2};
		end
	end

	for (genvar i = 0; i < C; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i] <= (i == 0) ? side_s3 : side_q[(i == 0) ? 0 : i - 1];
			end
		end
	end

	assign {wx, wy, wxy, wt} = side_q[C-1];

	ppcg_isqrt #(
		.RW(C)
	) u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (n_s3),
		.root     (rad)
	);

	ppcg_wave #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.PW(C)
	) u_wave_x (
		.clk    (clk),
		.en     (en),
		.pos    (wx),
		.scale  (spatial_scale_q),
		.k_mult (ppcg_pkg::K_SP_010),
		.t_mult (ppcg_pkg::T_100),
		.ticks  (wt),
		.sine   (sines[0])
	);

	ppcg_wave #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.PW(C)
	) u_wave_y (
		.clk    (clk),
		.en     (en),
		.pos    (wy),
		.scale  (spatial_scale_q),
		.k_mult (ppcg_pkg::K_SP_010),
		.t_mult (ppcg_pkg::T_130),
		.ticks  (wt),
		.sine   (sines[1])
	);

	ppcg_wave #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.PW(C + 1)
	) u_wave_xy (
		.clk    (clk),
		.en     (en),
		.pos    (wxy),
		.scale  (spatial_scale_q),
		.k_mult (ppcg_pkg::K_SP_005),
		.t_mult (ppcg_pkg::T_080),
		.ticks  (wt),
		.sine   (sines[2])
	);

	ppcg_wave #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
		.PW(C + 1)
	) u_wave_r (
		.clk    (clk),
		.en     (en),
		.pos    ($signed({1'b0, rad})),
		.scale  (spatial_scale_q),
		.k_mult (ppcg_pkg::K_SP_010),
		.t_mult (ppcg_pkg::T_170),
		.ticks  (wt),
		.sine   (sines[3])
	);

	ppcg_color u_color (
		.clk   (clk),
		.en    (en),
		.sines (sines),
		.cfg   (grad_cfg_q),
		.rgb   (rgb_last)
	);

	assign out_valid = skid_vld_q | vld_q[LAT-1];
	assign rgb_color = skid_vld_q ? skid_rgb_q : rgb_last;

endmodule

// File: design/ppcg_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module ppcg_isqrt #(
	parameter int RW = 16
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] radicand,
	output logic [RW-1:0]   root
);

	localparam int TW = 2 * RW + 2;

	logic [2*RW-1:0] rem_s  [RW];
	logic [RW-1:0]   root_s [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stage
		localparam int B = RW - 1 - j;
		logic [2*RW-1:0] rem_cur;
		logic [RW-1:0]   root_cur;
		logic [TW-1:0]   trial;
		logic [TW-1:0]   rem_ext;

		if (j == 0) begin : g_first
			assign rem_cur  = radicand;
			assign root_cur = '0;
		end else begin : g_next
			assign rem_cur  = rem_s[j-1];
			assign root_cur = root_s[j-1];
		end

		assign rem_ext = TW'(rem_cur);
		assign trial   = ((TW'(root_cur) << 1) + (TW'(1) << B)) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_ext >= trial) begin
					rem_s[j]  <= (2*RW)'(rem_ext - trial);
					root_s[j] <= root_cur | (RW'(1) << B);
				end else begin
					rem_s[j]  <= rem_cur;
					root_s[j] <= root_cur;
				end
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

// File: design/ppcg_wave.sv
// One travelling sine wave: phase from position and time, then quarter-wave ROM lookup.
module ppcg_wave #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PW = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [PW-1:0] pos,
	input  logic [15:0]          scale,
	input  logic [31:0]          k_mult,
	input  logic [31:0]          t_mult,
	input  logic [23:0]          ticks,
	output logic signed [15:0]   sine
);

	localparam int PB = $clog2(4 * SINE_TABLE_DEPTH);
	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam logic [PB:0]   QD  = (PB+1)'(4 * SINE_TABLE_DEPTH);
	localparam logic [PB-1:0] D1  = PB'(SINE_TABLE_DEPTH);
	localparam logic [PB-1:0] D2  = PB'(2 * SINE_TABLE_DEPTH);
	localparam logic [PB-1:0] D3  = PB'(3 * SINE_TABLE_DEPTH);
	localparam logic [AW-1:0] DA  = AW'(SINE_TABLE_DEPTH);

	typedef logic [15:0] rom_t [0:SINE_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] h;
		logic [63:0] s;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x  = 64'(i) * ppcg_pkg::PI_HALF_Q30 / 64'(SINE_TABLE_DEPTH);
			x2 = (x * x) >> 30;
			h  = ppcg_pkg::ONE_Q30 - x2 / 64'd110;
			h  = ppcg_pkg::ONE_Q30 - ((x2 * h) >> 30) / 64'd72;
			h  = ppcg_pkg::ONE_Q30 - ((x2 * h) >> 30) / 64'd42;
			h  = ppcg_pkg::ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
			h  = ppcg_pkg::ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
			s  = (x * h) >> 30;
			s  = (s + ppcg_pkg::AMP_SHIFT_ROUND) >> 16;
			if (s > 64'd16384) s = 64'd16384;
			r[i] = 16'(s);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic signed [PW+16:0] p_full;
	logic [55:0]           tp_full;
	logic [47:0]           p_s1;
	logic [31:0]           tp_s1;
	logic [55:0]           pl_full;
	logic [55:0]           ph_full;
	logic [47:0]           pl_s2;
	logic [23:0]           ph_s2;
	logic [31:0]           tp_s2;
	logic [47:0]           sp_sum;
	logic [31:0]           sp_s3;
	logic [31:0]           tp_s3;
	logic [31:0]           phase_s4;
	logic [PB+32:0]        pq_full;
	logic [PB-1:0]         p_s5;
	logic [1:0]            quad;
	logic [PB-1:0]         off_full;
	logic [AW-1:0]         off;
	logic [AW-1:0]         addr_s6;
	logic [1:0]            quad_s6;
	logic [15:0]           rom_s7;
	logic [1:0]            quad_s7;
	logic signed [15:0]    sine_s8;

	assign p_full  = pos * $signed({1'b0, scale});
	assign tp_full = 56'(ticks) * 56'(t_mult);
	assign pl_full = 56'(p_s1[23:0]) * 56'(k_mult);
	assign ph_full = 56'(p_s1[47:24]) * 56'(k_mult);
	assign sp_sum  = pl_s2 + {ph_s2, 24'd0};
	assign pq_full = (PB+33)'(phase_s4) * (PB+33)'(QD);

	always_comb begin
		priority if (p_s5 >= D3) begin
			quad     = 2'd3;
			off_full = p_s5 - D3;
		end else if (p_s5 >= D2) begin
			quad     = 2'd2;
			off_full = p_s5 - D2;
		end else if (p_s5 >= D1) begin
			quad     = 2'd1;
			off_full = p_s5 - D1;
		end else begin
			quad     = 2'd0;
			off_full = p_s5;
		end
		off = AW'(off_full);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1     <= 48'(p_full);
			tp_s1    <= tp_full[39:8];
			pl_s2    <= pl_full[47:0];
			ph_s2    <= ph_full[23:0];
			tp_s2    <= tp_s1;
			sp_s3    <= sp_sum[47:16];
			tp_s3    <= tp_s2;
			phase_s4 <= sp_s3 + tp_s3;
			p_s5     <= pq_full[PB+31:32];
			addr_s6  <= quad[0] ? DA - off : off;
			quad_s6  <= quad;
			rom_s7   <= SINE_ROM[addr_s6];
			quad_s7  <= quad_s6;
			sine_s8  <= quad_s7[1] ? -$signed(rom_s7) : $signed(rom_s7);
		end
	end

	assign sine = sine_s8;

endmodule

// File: design/ppcg_color.sv
// Plasma level from the four waves, then gradient blend or rainbow hue.
module ppcg_color (
	input  logic                clk,
	input  logic                en,
	input  logic signed [15:0]  sines [4],
	input  ppcg_pkg::grad_cfg_t cfg,
	output logic [23:0]         rgb
);

	typedef enum logic [2:0] {
		HUE_RED_YEL = 3'd0,
		HUE_YEL_GRN = 3'd1,
		HUE_GRN_CYA = 3'd2,
		HUE_CYA_BLU = 3'd3,
		HUE_BLU_MAG = 3'd4,
		HUE_MAG_RED = 3'd5
	} hue_sector_t;

	logic signed [17:0] sum_s1;
	logic [17:0]        u;
	logic [26:0]        m;
	logic [7:0]         level_s2;
	logic [7:0]         inv;
	logic [15:0]        n [3];
	logic [15:0]        n_s3 [3];
	logic [10:0]        h;
	logic [10:0]        f_full;
	logic [7:0]         f;
	logic [7:0]         x;
	hue_sector_t        sector;
	logic [23:0]        hue_rgb;
	logic [23:0]        hue_s3;
	logic               mode_s3;
	logic [31:0]        q_s4 [3];
	logic [23:0]        hue_s4;
	logic               mode_s4;
	logic [23:0]        rgb_s5;

	assign u   = 18'(unsigned'(sum_s1) + 18'd65536);
	assign m   = 27'(u) * 27'd255 + 27'd65536;
	assign inv = 8'd255 - level_s2;
	assign h   = 11'(level_s2) * 11'd6;

	for (genvar c = 0; c < 3; c++) begin : g_blend
		assign n[c] = 16'(cfg.start_color[8*c +: 8]) * 16'(inv)
			+ 16'(cfg.end_color[8*c +: 8]) * 16'(level_s2) + 16'd127;
	end

	always_comb begin
		priority if (h >= 11'd1530) begin
			sector = HUE_RED_YEL;
			f_full = h - 11'd1530;
		end else if (h >= 11'd1275) begin
			sector = HUE_MAG_RED;
			f_full = h - 11'd1275;
		end else if (h >= 11'd1020) begin
			sector = HUE_BLU_MAG;
			f_full = h - 11'd1020;
		end else if (h >= 11'd765) begin
			sector = HUE_CYA_BLU;
			f_full = h - 11'd765;
		end else if (h >= 11'd510) begin
			sector = HUE_GRN_CYA;
			f_full = h - 11'd510;
		end else if (h >= 11'd255) begin
			sector = HUE_YEL_GRN;
			f_full = h - 11'd255;
		end else begin
			sector = HUE_RED_YEL;
			f_full = h;
		end
		f = f_full[7:0];
		x = (sector == HUE_YEL_GRN || sector == HUE_CYA_BLU || sector == HUE_MAG_RED)
			? 8'd255 - f : f;
		unique case (sector)
			HUE_RED_YEL: hue_rgb = {8'd255, x, 8'd0};
			HUE_YEL_GRN: hue_rgb = {x, 8'd255, 8'd0};
			HUE_GRN_CYA: hue_rgb = {8'd0, 8'd255, x};
			HUE_CYA_BLU: hue_rgb = {8'd0, x, 8'd255};
			HUE_BLU_MAG: hue_rgb = {x, 8'd0, 8'd255};
			HUE_MAG_RED: hue_rgb = {8'd255, 8'd0, x};
			default:     hue_rgb = {8'd255, 8'd0, x};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1   <= 18'(sines[0]) + 18'(sines[1]) + 18'(sines[2]) + 18'(sines[3]);
			level_s2 <= (m[26:17] > 10'd255) ? 8'd255 : m[24:17];
			n_s3     <= n;
			hue_s3   <= hue_rgb;
			mode_s3  <= cfg.gradient_mode;
			for (int c = 0; c < 3; c++) begin
				q_s4[c] <= 32'(n_s3[c]) * 32'd32897;
			end
			hue_s4   <= hue_s3;
			mode_s4  <= mode_s3;
			rgb_s5   <= mode_s4 ? {q_s4[2][30:23], q_s4[1][30:23], q_s4[0][30:23]} : hue_s4;
		end
	end

	assign rgb = rgb_s5;

endmodule

// File: dv/plasma_pattern_color_generator_checker.sv
// Checker for the plasma colour generator: watches both channels, predicts colours, compares.
`timescale 1ns / 100ps
module plasma_pattern_color_generator_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [23:0] time_ticks,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [23:0] rgb_color,
	output int          fail_count,
	output int          colours_pending
);
	localparam int DEPTH = 1024;

	logic [15:0] sine_quarter [0:DEPTH];
	logic [15:0] scale_q88;
	logic        blend_on;
	logic [23:0] colour_lo;
	logic [23:0] colour_hi;
	logic [23:0] colour_queue [$];

	initial begin
		logic [63:0] ang, ang2, poly, s;
		for (int i = 0; i <= DEPTH; i++) begin
			ang = 64'(i) * ppcg_pkg::PI_HALF_Q30 / DEPTH;
			ang2 = (ang * ang) >> 30;
			poly = ppcg_pkg::ONE_Q30 - ang2 / 110;
			poly = ppcg_pkg::ONE_Q30 - ((ang2 * poly) >> 30) / 72;
			poly = ppcg_pkg::ONE_Q30 - ((ang2 * poly) >> 30) / 42;
			poly = ppcg_pkg::ONE_Q30 - ((ang2 * poly) >> 30) / 20;
			poly = ppcg_pkg::ONE_Q30 - ((ang2 * poly) >> 30) / 6;
			s = (ang * poly) >> 30;
			s = (s + ppcg_pkg::AMP_SHIFT_ROUND) >> 16;
			if (s > 16384) s = 16384;
			sine_quarter[i] = s[15:0];
		end
	end

	function automatic logic [63:0] root_floor(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic int wave_sine(input logic [31:0] phase);
		logic [63:0] idx;
		int q, o, v;
		idx = (64'(phase) * (4 * DEPTH)) >> 32;
		q = int'(idx / DEPTH) & 3;
		o = int'(idx % DEPTH);
		v = (q & 1) ? int'(sine_quarter[DEPTH - o]) : int'(sine_quarter[o]);
		return (q & 2) ? -v : v;
	endfunction

	function automatic logic [23:0] plasma_colour(input logic [15:0] px, input logic [15:0] py,
			input logic [23:0] tk);
		logic [63:0] sx, sy, sc, rad, t64;
		logic [31:0] p1, p2, p3, p4;
		int sum;
		logic [63:0] lvl;
		int level, inv, h, sector, f, x, r, g, b;
		sx = {{48{px[15]}}, px};
		sy = {{48{py[15]}}, py};
		sc = 64'(scale_q88);
		t64 = 64'(tk);
		rad = root_floor(sx * sx + sy * sy);
		p1 = 32'(((sx * sc) * ppcg_pkg::K_SP_010) >> 16)
			+ 32'((t64 * ppcg_pkg::T_100) >> 8);
		p2 = 32'(((sy * sc) * ppcg_pkg::K_SP_010) >> 16)
			+ 32'((t64 * ppcg_pkg::T_130) >> 8);
		p3 = 32'((((sx + sy) * sc) * ppcg_pkg::K_SP_005) >> 16)
			+ 32'((t64 * ppcg_pkg::T_080) >> 8);
		p4 = 32'(((rad * sc) * ppcg_pkg::K_SP_010) >> 16)
			+ 32'((t64 * ppcg_pkg::T_170) >> 8);
		sum = wave_sine(p1) + wave_sine(p2) + wave_sine(p3) + wave_sine(p4);
		lvl = (64'(32'(sum + 65536)) * 255 + 65536) >> 17;
		level = (lvl > 255) ? 255 : int'(lvl);
		if (blend_on) begin
			inv = 255 - level;
			r = (colour_lo[23:16] * inv + colour_hi[23:16] * level + 127) / 255;
			g = (colour_lo[15:8] * inv + colour_hi[15:8] * level + 127) / 255;
			b = (colour_lo[7:0] * inv + colour_hi[7:0] * level + 127) / 255;
		end else begin
			h = level * 6;
			sector = (h / 255) % 6;
			f = h % 255;
			x = (sector & 1) ? 255 - f : f;
			case (sector)
				0: begin r = 255; g = x; b = 0; end
				1: begin r = x; g = 255; b = 0; end
				2: begin r = 0; g = 255; b = x; end
				3: begin r = 0; g = x; b = 255; end
				4: begin r = x; g = 0; b = 255; end
				default: begin r = 255; g = 0; b = x; end
			endcase
		end
		return {r[7:0], g[7:0], b[7:0]};
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		fail_count++;
	endtask

	assign colours_pending = colour_queue.size();

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q88 <= ppcg_pkg::SPATIAL_SCALE_RESET;
			blend_on  <= 1'b0;
			colour_lo <= ppcg_pkg::START_COLOR_RESET;
			colour_hi <= ppcg_pkg::END_COLOR_RESET;
			colour_queue.delete();
		end else begin
			if (in_valid && in_ready)
				colour_queue.push_back(plasma_colour(pos_x, pos_y, time_ticks));
			if (out_valid && out_ready) begin
				if (colour_queue.size() == 0)
					report_mismatch($sformatf("unexpected colour %06h", rgb_color));
				else if (colour_queue[0] !== rgb_color)
					report_mismatch($sformatf("rgb_color %06h, expected %06h",
						rgb_color, colour_queue.pop_front()));
				else
					void'(colour_queue.pop_front());
			end
			if (cfg_we) begin
				case (ppcg_pkg::cfg_reg_t'(cfg_index))
					ppcg_pkg::CFG_SPATIAL_SCALE: scale_q88 <= cfg_data[15:0];
					ppcg_pkg::CFG_GRADIENT_MODE: blend_on  <= cfg_data[0];
					ppcg_pkg::CFG_START_COLOR:   colour_lo <= cfg_data;
					ppcg_pkg::CFG_END_COLOR:     colour_hi <= cfg_data;
				endcase
			end
		end
	end
endmodule

// File: dv/plasma_pattern_color_generator_test.sv
// Testbench top of the plasma colour generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module plasma_pattern_color_generator_test;

	localparam int LATENCY = 16 + 16;
	localparam longint CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [23:0] cfg_data = 24'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] pos_x = 16'd0;
	logic [15:0] pos_y = 16'd0;
	logic [23:0] time_ticks = 24'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [23:0] rgb_color;
	int          fail_count;
	int          colours_pending;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	longint      cycle_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	plasma_pattern_color_generator u_top (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
		.pos_x, .pos_y, .time_ticks, .out_valid, .out_ready, .rgb_color
	);

	plasma_pattern_color_generator_checker u_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
		.pos_x, .pos_y, .time_ticks, .out_valid, .out_ready, .rgb_color,
		.fail_count, .colours_pending
	);

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("plasma_pattern_color_generator_test NOT OK");
			$finish;
		end
	end

	task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
			input logic [23:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		pos_x      <= x;
		pos_y      <= y;
		time_ticks <= t;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (colours_pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(input ppcg_pkg::cfg_reg_t idx, input logic [23:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_burst(input int count);
		logic [15:0] x, y;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(3))
				0: begin x = 16'($urandom); y = 16'($urandom); end
				default: begin
					x = 16'($signed($urandom_range(8191)) - 4096);
					y = 16'($signed($urandom_range(8191)) - 4096);
				end
			endcase
			send_pixel(x, y, ($urandom_range(3) == 0) ? 24'($urandom)
				: 24'($urandom_range(5000)));
		end
	endtask

	initial begin
		logic [15:0] edge_xy [6];
		edge_xy = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0100, 16'hFF00};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (edge_xy[i])
			send_pixel(edge_xy[i], edge_xy[(i + 1) % 6], (i % 2) ? 24'hFFFFFF : 24'd0);
		for (int t = 0; t < 12; t++)
			send_pixel(16'd0, 16'd0, 24'(t * 53));
		drain_pipe();
		write_reg(ppcg_pkg::CFG_SPATIAL_SCALE, 24'hFFFF);
		write_reg(ppcg_pkg::CFG_GRADIENT_MODE, 24'd1);
		write_reg(ppcg_pkg::CFG_START_COLOR, 24'h000000);
		write_reg(ppcg_pkg::CFG_END_COLOR, 24'hFFFFFF);
		foreach (edge_xy[i])
			send_pixel(edge_xy[i], edge_xy[5 - i], 24'($urandom));
		drain_pipe();
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 77; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 77; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			write_reg(ppcg_pkg::CFG_SPATIAL_SCALE, (phase == 4) ? 24'd0 : 24'($urandom));
			write_reg(ppcg_pkg::CFG_GRADIENT_MODE, 24'(phase % 2));
			write_reg(ppcg_pkg::CFG_START_COLOR, 24'($urandom));
			write_reg(ppcg_pkg::CFG_END_COLOR, 24'($urandom));
			random_burst(125);
			drain_pipe();
			random_burst(125);
			drain_pipe();
		end
		while (colours_pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		if (fail_count == 0)
			$display("plasma_pattern_color_generator_test OK");
		else
			$display("plasma_pattern_color_generator_test NOT OK");
		$finish;
	end
endmodule

// File: plasma_pattern_color_generator.f
design/ppcg_pkg.sv
design/ppcg_isqrt.sv
design/ppcg_wave.sv
design/ppcg_color.sv
design/plasma_pattern_color_generator.sv
dv/plasma_pattern_color_generator_checker.sv
dv/plasma_pattern_color_generator_test.sv
